// ===== rtl/i2c_memory_access_master_assert.svh =====
// Assertion macros for the I2C memory-access master checker.
`ifndef I2C_MEMORY_ACCESS_MASTER_ASSERT_SVH
`define I2C_MEMORY_ACCESS_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define I2CMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define I2CMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cma_pkg.sv =====
// Types and constants shared by the I2C memory-access master modules.
package i2cma_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);

  localparam int HP_W    = 10;
  localparam int TO_W    = 16;
  localparam int TIMER_W = 16;
  localparam int LEN_W   = 16;

  localparam logic [HP_W-1:0] HALF_PERIOD_RST = 10'd5;
  localparam logic [TO_W-1:0] ACK_TIMEOUT_RST = 16'd1000;

  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_PUSH     = 2'd1,
    CMD_START_WR = 2'd2,
    CMD_START_RD = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ST_LOW   = 4'd1,
    PH_ST_HIGH  = 4'd2,
    PH_ST_HOLD  = 4'd3,
    PH_TX_LOW   = 4'd4,
    PH_TX_HIGH  = 4'd5,
    PH_ACK_LOW  = 4'd6,
    PH_ACK_WAIT = 4'd7,
    PH_RX_LOW   = 4'd8,
    PH_RX_HIGH  = 4'd9,
    PH_MA_LOW   = 4'd10,
    PH_MA_HIGH  = 4'd11,
    PH_SP_LOW   = 4'd12,
    PH_SP_HIGH  = 4'd13,
    PH_SP_HOLD  = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    SG_DEV_W  = 3'd0,
    SG_ADR_HI = 3'd1,
    SG_ADR_LO = 3'd2,
    SG_DEV_R  = 3'd3,
    SG_DATA   = 3'd4
  } stage_t;

  typedef struct packed {
    logic             rd;
    logic [LEN_W-1:0] len;
    logic             wide;
    logic [15:0]      mem;
    logic [6:0]       dev;
  } req_t;

  typedef struct packed {
    cmd_t             command;
    logic             sda_in;
    logic [6:0]       device_address;
    logic [15:0]      mem_address;
    logic             wide_address;
    logic [LEN_W-1:0] length;
    logic [7:0]       write_byte;
  } seq_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       success;
    logic       rejected;
  } seq_out_t;

endpackage

// ===== rtl/i2cma_seq.sv =====
// Bit sequencer and transmit buffer of the I2C memory-access master.
module i2cma_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  i2cma_pkg::seq_in_t            beat,
  input  logic [i2cma_pkg::HP_W-1:0]    half_period,
  input  logic [i2cma_pkg::TO_W-1:0]    ack_timeout,
  output i2cma_pkg::seq_out_t           res
);
  import i2cma_pkg::*;

  phase_t              phase_r, phase_nxt;
  stage_t              stage_r, stage_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt;
  logic [3:0]          bit_cnt_r, bit_cnt_nxt;
  logic [LEN_W-1:0]    byte_cnt_r, byte_cnt_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [PTR_W-1:0]    fill_r, fill_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  req_t                req_r, req_nxt;
  logic                abort_r, abort_nxt;

  logic [7:0]          tx_mem [BUFFER_DEPTH];
  logic                mem_we;
  logic [7:0]          tx_rd_r;

  logic                rvalid, rlast, done, succ, rej;
  logic [7:0]          rdata;

  // ptr_r settles a full byte time before an ACK needs the next data byte
  always_ff @(posedge clk) begin
    if (step && mem_we) begin
      tx_mem[fill_r[IDX_W-1:0]] <= beat.write_byte;
    end
    tx_rd_r <= tx_mem[ptr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      stage_r    <= SG_DEV_W;
      timer_r    <= '0;
      bit_cnt_r  <= '0;
      byte_cnt_r <= '0;
      shift_r    <= '0;
      fill_r     <= '0;
      ptr_r      <= '0;
      req_r      <= '0;
      abort_r    <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      stage_r    <= stage_nxt;
      timer_r    <= timer_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      shift_r    <= shift_nxt;
      fill_r     <= fill_nxt;
      ptr_r      <= ptr_nxt;
      req_r      <= req_nxt;
      abort_r    <= abort_nxt;
    end
  end

  // next state
  always_comb begin
    logic [TIMER_W-1:0] timer_inc;
    logic [3:0]         bit_inc;
    logic [7:0]         rx_shift;
    logic               next_data;

    phase_nxt    = phase_r;
    stage_nxt    = stage_r;
    timer_nxt    = timer_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    fill_nxt     = fill_r;
    ptr_nxt      = ptr_r;
    req_nxt      = req_r;
    abort_nxt    = abort_r;
    mem_we       = 1'b0;
    rvalid       = 1'b0;
    rdata        = '0;
    rlast        = 1'b0;
    done         = 1'b0;
    succ         = 1'b0;
    rej          = 1'b0;
    next_data    = 1'b0;
    timer_inc    = timer_r + 1'b1;
    bit_inc      = bit_cnt_r + 1'b1;
    rx_shift     = {shift_r[6:0], beat.sda_in};

    if (phase_r == PH_IDLE) begin
      if (beat.command == CMD_PUSH) begin
        if (fill_r < PTR_W'(BUFFER_DEPTH)) begin
          mem_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end else begin
          rej = 1'b1;
        end
      end else if (beat.command inside {CMD_START_WR, CMD_START_RD}) begin
        if (beat.command == CMD_START_WR && beat.length > LEN_W'(fill_r)) begin
          rej = 1'b1;
        end else begin
          req_nxt.dev  = beat.device_address;
          req_nxt.mem  = beat.mem_address;
          req_nxt.wide = beat.wide_address;
          req_nxt.len  = beat.length;
          req_nxt.rd   = (beat.command == CMD_START_RD);
          stage_nxt    = SG_DEV_W;
          byte_cnt_nxt = '0;
          bit_cnt_nxt  = '0;
          ptr_nxt      = '0;
          abort_nxt    = 1'b0;
          phase_nxt    = PH_ST_HIGH;
          timer_nxt    = '0;
        end
      end
    end else begin
      rej = (beat.command != CMD_TICK);
      if (phase_r == PH_ACK_WAIT) begin
        if (!beat.sda_in) begin
          timer_nxt = '0;
          case (stage_r)
            SG_DEV_W: begin
              stage_nxt   = req_r.wide ? SG_ADR_HI : SG_ADR_LO;
              shift_nxt   = req_r.wide ? req_r.mem[15:8] : req_r.mem[7:0];
              bit_cnt_nxt = '0;
              phase_nxt   = PH_TX_LOW;
            end
            SG_ADR_HI: begin
              stage_nxt   = SG_ADR_LO;
              shift_nxt   = req_r.mem[7:0];
              bit_cnt_nxt = '0;
              phase_nxt   = PH_TX_LOW;
            end
            SG_ADR_LO: begin
              if (req_r.rd) begin
                stage_nxt = SG_DEV_R;
                phase_nxt = PH_ST_LOW;
              end else begin
                next_data = 1'b1;
              end
            end
            SG_DEV_R: begin
              if (req_r.len == '0) begin
                phase_nxt = PH_SP_LOW;
              end else begin
                byte_cnt_nxt = '0;
                bit_cnt_nxt  = '0;
                shift_nxt    = '0;
                phase_nxt    = PH_RX_LOW;
              end
            end
            default: next_data = 1'b1;
          endcase
          if (next_data) begin
            if (byte_cnt_r < req_r.len && ptr_r < PTR_W'(BUFFER_DEPTH)) begin
              stage_nxt    = SG_DATA;
              byte_cnt_nxt = byte_cnt_r + 1'b1;
              shift_nxt    = tx_rd_r;
              bit_cnt_nxt  = '0;
              ptr_nxt      = ptr_r + 1'b1;
              phase_nxt    = PH_TX_LOW;
            end else begin
              phase_nxt = PH_SP_LOW;
            end
          end
        end else if (timer_r >= ack_timeout) begin
          abort_nxt = 1'b1;
          phase_nxt = PH_SP_LOW;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
        end
      end else if (timer_inc >= TIMER_W'(half_period)) begin
        timer_nxt = '0;
        case (phase_r)
          PH_ST_LOW:  phase_nxt = PH_ST_HIGH;
          PH_ST_HIGH: phase_nxt = PH_ST_HOLD;
          PH_ST_HOLD: begin
            shift_nxt   = {req_r.dev, stage_r == SG_DEV_R};
            bit_cnt_nxt = '0;
            phase_nxt   = PH_TX_LOW;
          end
          PH_TX_LOW:  phase_nxt = PH_TX_HIGH;
          PH_TX_HIGH: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            phase_nxt   = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
          end
          PH_ACK_LOW: phase_nxt = PH_ACK_WAIT;
          PH_RX_LOW:  phase_nxt = PH_RX_HIGH;
          PH_RX_HIGH: begin
            shift_nxt   = rx_shift;
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= 4'd8) begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
              rvalid       = 1'b1;
              rdata        = rx_shift;
              rlast        = (byte_cnt_r + 1'b1 >= req_r.len);
              phase_nxt    = PH_MA_LOW;
            end else begin
              phase_nxt = PH_RX_LOW;
            end
          end
          PH_MA_LOW:  phase_nxt = PH_MA_HIGH;
          PH_MA_HIGH: begin
            if (byte_cnt_r >= req_r.len) begin
              phase_nxt = PH_SP_LOW;
            end else begin
              bit_cnt_nxt = '0;
              shift_nxt   = '0;
              phase_nxt   = PH_RX_LOW;
            end
          end
          PH_SP_LOW:  phase_nxt = PH_SP_HIGH;
          PH_SP_HIGH: phase_nxt = PH_SP_HOLD;
          default: begin
            done = 1'b1;
            succ = !abort_r;
            if (!req_r.rd) begin
              fill_nxt = '0;
              ptr_nxt  = '0;
            end
            phase_nxt = PH_IDLE;
          end
        endcase
      end else begin
        timer_nxt = timer_inc;
      end
    end
  end

  // outputs
  always_comb begin
    logic ma_bit;
    ma_bit = (byte_cnt_nxt >= req_nxt.len);
    res.scl_out = 1'b1;
    res.sda_out = 1'b1;
    case (phase_nxt)
      PH_ST_LOW:  begin res.scl_out = 1'b0; res.sda_out = 1'b1;         end
      PH_ST_HOLD: begin res.scl_out = 1'b1; res.sda_out = 1'b0;         end
      PH_TX_LOW:  begin res.scl_out = 1'b0; res.sda_out = shift_nxt[7]; end
      PH_TX_HIGH: begin res.scl_out = 1'b1; res.sda_out = shift_nxt[7]; end
      PH_ACK_LOW: begin res.scl_out = 1'b0; res.sda_out = 1'b1;         end
      PH_RX_LOW:  begin res.scl_out = 1'b0; res.sda_out = 1'b1;         end
      PH_MA_LOW:  begin res.scl_out = 1'b0; res.sda_out = ma_bit;       end
      PH_MA_HIGH: begin res.scl_out = 1'b1; res.sda_out = ma_bit;       end
      PH_SP_LOW:  begin res.scl_out = 1'b0; res.sda_out = 1'b0;         end
      PH_SP_HIGH: begin res.scl_out = 1'b1; res.sda_out = 1'b0;         end
      default:    begin res.scl_out = 1'b1; res.sda_out = 1'b1;         end
    endcase
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.read_valid = rvalid;
    res.read_data  = rdata;
    res.read_last  = rlast;
    res.done_res   = done;
    res.success    = succ;
    res.rejected   = rej;
  end

endmodule

// ===== rtl/i2c_memory_access_master.sv =====
// Top level of the I2C memory-access master: handshake, registers, result stage.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_ready  | one tick or command
//   out_    | output    | out_valid/out_ready| pin levels and status after it
//   cfg_    | input     | APB psel/penable   | half_period, ack_timeout
//
// One input beat per cycle while in_ready is high; its result is registered.
// in_ready is high whenever the result register is empty or being drained.
// Sequencer state, counters and out_valid clear on synchronous rst_n.
// The 16-entry transmit buffer is not cleared; its fill count tracks valid bytes.
module i2c_memory_access_master (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_sda_in,
  input  logic [6:0]  in_device_address,
  input  logic [15:0] in_mem_address,
  input  logic        in_wide_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_write_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_read_valid,
  output logic [7:0]  out_read_data,
  output logic        out_read_last,
  output logic        out_done_res,
  output logic        out_success,
  output logic        out_rejected,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cma_pkg::*;

  logic [HP_W-1:0] half_period_r;
  logic [TO_W-1:0] ack_timeout_r;
  logic            out_valid_r;
  seq_out_t        out_r;
  seq_in_t         beat;
  seq_out_t        res;
  logic            step;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HALF_PERIOD) begin
        half_period_r <= pwdata[HP_W-1:0];
      end else begin
        ack_timeout_r <= pwdata[TO_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HALF_PERIOD) ? 32'(half_period_r) : 32'(ack_timeout_r);

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  assign beat.command        = cmd_t'(in_command);
  assign beat.sda_in         = in_sda_in;
  assign beat.device_address = in_device_address;
  assign beat.mem_address    = in_mem_address;
  assign beat.wide_address   = in_wide_address;
  assign beat.length         = in_length;
  assign beat.write_byte     = in_write_byte;

  i2cma_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .beat        (beat),
    .half_period (half_period_r),
    .ack_timeout (ack_timeout_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_out    = out_r.scl_out;
  assign out_sda_out    = out_r.sda_out;
  assign out_busy_res   = out_r.busy_res;
  assign out_read_valid = out_r.read_valid;
  assign out_read_data  = out_r.read_data;
  assign out_read_last  = out_r.read_last;
  assign out_done_res   = out_r.done_res;
  assign out_success    = out_r.success;
  assign out_rejected   = out_r.rejected;

endmodule

// ===== rtl/i2cma_checker.sv =====
// Port-level checker for the I2C memory-access master, bound to the top level.
`include "i2c_memory_access_master_assert.svh"

module i2cma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_scl_out,
  input logic        out_sda_out,
  input logic        out_busy_res,
  input logic        out_read_valid,
  input logic [7:0]  out_read_data,
  input logic        out_read_last,
  input logic        out_done_res,
  input logic        out_success,
  input logic        out_rejected
);

  logic [15:0] out_beat;

  assign out_beat = {out_scl_out, out_sda_out, out_busy_res, out_read_valid, out_read_data,
                     out_read_last, out_done_res, out_success, out_rejected};

  `I2CMA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_beat), "result beat changed while stalled")
  `I2CMA_ASSERT_IMP(a_in_stall, in_valid && !in_ready,
    out_valid && !out_ready, "input stalled with result register free")
  `I2CMA_ASSERT_IMP(a_done_idle, out_valid && out_done_res,
    !out_busy_res && !out_read_valid, "done beat still busy")
  `I2CMA_ASSERT_IMP(a_rx_busy, out_valid && out_read_valid,
    out_busy_res && !out_done_res, "read byte outside transaction")
  `I2CMA_ASSERT_IMP(a_succ_done, out_valid && (out_success || out_read_last),
    out_done_res || out_read_valid, "status flag without its beat")

endmodule

bind i2c_memory_access_master i2cma_checker u_i2cma_checker (.*);
